[sv/bsc_pkg.sv]
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int RAW_W       = 24;
    localparam int COEF_W      = 16;
    localparam int CFG_IDX_W   = 3;

    localparam int DT_W        = 25;
    localparam int PROD1_W     = 42;
    localparam int DTSQ_W      = 49;
    localparam int Q_W         = 18;
    localparam int TEMP1_W     = 19;
    localparam int B_W         = 19;
    localparam int T2_W        = 17;
    localparam int OFF1_W      = 37;
    localparam int SENS1_W     = 36;
    localparam int SQ_W        = 35;
    localparam int OFF2_W      = 40;
    localparam int SENS2_W     = 39;
    localparam int TEMP2_W     = 20;
    localparam int OFFF_W      = 42;
    localparam int SENSF_W     = 41;
    localparam int LO_W        = 20;
    localparam int PPLO_W      = 44;
    localparam int PPHI_W      = 46;
    localparam int PROD_W      = 66;
    localparam int PRESS_W     = 31;

    localparam int TEMP_OUT_W  = 15;
    localparam int PRESS_OUT_W = 18;

    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SHIFT   = 6;
    localparam int SENS_SHIFT  = 7;
    localparam int OFF_SCALE   = 17;
    localparam int SENS_SCALE  = 16;
    localparam int REF_SCALE   = 8;
    localparam int P1_SHIFT    = 21;
    localparam int P2_SHIFT    = 15;
    localparam int SQ_SHIFT    = 4;

    localparam int TEMP_BASE    = 2000;
    localparam int VCOLD_LIMIT  = 1500;
    localparam int VCOLD_OFFSET = TEMP_BASE + VCOLD_LIMIT;

    localparam int T2_WARM_MUL = 5;
    localparam int T2_WARM_SH  = 38;
    localparam int T2_COLD_MUL = 3;
    localparam int T2_COLD_SH  = 33;
    localparam int OFF2_COLD   = 61;
    localparam int SENS2_COLD  = 29;
    localparam int OFF2_VCOLD  = 17;
    localparam int SENS2_VCOLD = 9;

    localparam int TEMP_LOW   = -4000;
    localparam int TEMP_HIGH  = 8500;
    localparam int PRESS_HIGH = 200000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_COEF,
        REG_OFFSET_COEF,
        REG_SENS_TEMPCO,
        REG_OFFSET_TEMPCO,
        REG_REF_TEMP_COEF,
        REG_TEMP_SLOPE_COEF
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens_coef;
        logic [COEF_W-1:0] offset_coef;
        logic [COEF_W-1:0] sens_tempco;
        logic [COEF_W-1:0] offset_tempco;
        logic [COEF_W-1:0] ref_temp_coef;
        logic [COEF_W-1:0] temp_slope_coef;
    } cfg_t;

    typedef struct packed {
        logic        [RAW_W-1:0]   d1;
        logic signed [TEMP1_W-1:0] temp1;
        logic signed [Q_W-1:0]     a;
        logic signed [B_W-1:0]     b;
        logic        [T2_W-1:0]    t2;
        logic                      cold;
        logic                      vcold;
        logic signed [OFF1_W-1:0]  off1;
        logic signed [SENS1_W-1:0] sens1;
    } front_t;

    typedef struct packed {
        logic        [RAW_W-1:0]      d1;
        logic signed [TEMP_OUT_W-1:0] temp_c;
        logic                         clip_t;
        logic signed [OFFF_W-1:0]     off_f;
        logic signed [SENSF_W-1:0]    sens_f;
    } corr_t;

endpackage

[sv/baro_sensor_compensation.sv]
`timescale 1ns / 1ps
// Ten register stages from input transaction to result.
// Throughput: one transaction per cycle; each stage holds under back-pressure
// and accepts again as soon as the stage after it frees up.
// Reset: rst_n asynchronous, active low; empties the pipeline and clears all
// six calibration registers to zero.

module baro_sensor_compensation (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [bsc_pkg::COEF_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [bsc_pkg::RAW_W-1:0]              raw_pressure,
    input  logic [bsc_pkg::RAW_W-1:0]              raw_temperature,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bsc_pkg::TEMP_OUT_W-1:0]  temp_centi,
    output logic        [bsc_pkg::PRESS_OUT_W-1:0] press_centi_mbar,
    output logic                                   clipped
);
    import bsc_pkg::*;

    cfg_t   cfg_reg;
    front_t front_data;
    logic   front_valid;
    logic   front_ready;
    corr_t  corr_data;
    logic   corr_valid;
    logic   corr_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SENS_COEF:       cfg_reg.sens_coef       <= cfg_data;
                REG_OFFSET_COEF:     cfg_reg.offset_coef     <= cfg_data;
                REG_SENS_TEMPCO:     cfg_reg.sens_tempco     <= cfg_data;
                REG_OFFSET_TEMPCO:   cfg_reg.offset_tempco   <= cfg_data;
                REG_REF_TEMP_COEF:   cfg_reg.ref_temp_coef   <= cfg_data;
                REG_TEMP_SLOPE_COEF: cfg_reg.temp_slope_coef <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bsc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (front_valid),
        .out_ready       (front_ready),
        .out_data        (front_data)
    );

    bsc_corr u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    bsc_press u_press (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (corr_valid),
        .in_ready         (corr_ready),
        .in_data          (corr_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .temp_centi       (temp_centi),
        .press_centi_mbar (press_centi_mbar),
        .clipped          (clipped)
    );

    // empty output stage means the whole ready chain is open
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with output stage empty");

    a_out_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (press_centi_mbar <= PRESS_OUT_W'(PRESS_HIGH))
                   && (temp_centi >= TEMP_OUT_W'(TEMP_LOW))
                   && (temp_centi <= TEMP_OUT_W'(TEMP_HIGH)))
        else $error("result outside saturation range");

    a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |-> (press_centi_mbar == '0)
                                || (press_centi_mbar == PRESS_OUT_W'(PRESS_HIGH))
                                || (temp_centi == TEMP_OUT_W'(TEMP_LOW))
                                || (temp_centi == TEMP_OUT_W'(TEMP_HIGH)))
        else $error("clip flag set with no output at a bound");

endmodule

[sv/bsc_front.sv]
`timescale 1ns / 1ps

module bsc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsc_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bsc_pkg::RAW_W-1:0]   raw_pressure,
    input  logic [bsc_pkg::RAW_W-1:0]   raw_temperature,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bsc_pkg::front_t             out_data
);
    import bsc_pkg::*;

    localparam logic signed [Q_W-1:0]     VCOLD_Q   = Q_W'(-VCOLD_OFFSET);
    localparam logic signed [TEMP1_W-1:0] BASE_T    = TEMP1_W'(TEMP_BASE);
    localparam logic signed [B_W-1:0]     VCOLD_B   = B_W'(VCOLD_OFFSET);
    localparam int                        TW_W      = DTSQ_W + 2;
    localparam int                        TC_W      = DTSQ_W + 1;

    logic [2:0] valid_reg;
    logic [2:0] en;

    logic        [RAW_W-1:0]   d1_s1_reg;
    logic signed [DT_W-1:0]    dt_s1_reg;
    logic signed [DT_W-1:0]    dt_next;

    logic        [RAW_W-1:0]   d1_s2_reg;
    logic signed [PROD1_W-1:0] ptemp_s2_reg;
    logic signed [PROD1_W-1:0] poff_s2_reg;
    logic signed [PROD1_W-1:0] psens_s2_reg;
    logic        [DTSQ_W-1:0]  dtsq_s2_reg;
    logic signed [PROD1_W-1:0] ptemp_next;
    logic signed [PROD1_W-1:0] poff_next;
    logic signed [PROD1_W-1:0] psens_next;
    logic signed [2*DT_W-1:0]  dtsq_full;

    front_t                    out_reg;
    front_t                    out_next;
    logic signed [Q_W-1:0]     q;
    logic signed [PROD1_W-1:0] off_sh;
    logic signed [PROD1_W-1:0] sens_sh;
    logic        [TW_W-1:0]    tw;
    logic        [TC_W-1:0]    tc;

    always_comb
    begin
        en[2] = !valid_reg[2] || out_ready;
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    // dT
    always_comb
    begin
        dt_next = $signed({1'b0, raw_temperature})
                - $signed({1'b0, cfg.ref_temp_coef, {REF_SCALE{1'b0}}});
    end

    // first-order products and dT squared
    always_comb
    begin
        ptemp_next = dt_s1_reg * $signed({1'b0, cfg.temp_slope_coef});
        poff_next  = dt_s1_reg * $signed({1'b0, cfg.offset_tempco});
        psens_next = dt_s1_reg * $signed({1'b0, cfg.sens_tempco});
        dtsq_full  = dt_s1_reg * dt_s1_reg;
    end

    // first-order terms and the range flags
    always_comb
    begin
        q       = $signed(ptemp_s2_reg[TEMP_SHIFT+Q_W-1:TEMP_SHIFT]);
        off_sh  = poff_s2_reg >>> OFF_SHIFT;
        sens_sh = psens_s2_reg >>> SENS_SHIFT;
        tw      = TW_W'(dtsq_s2_reg) * TW_W'(T2_WARM_MUL);
        tc      = TC_W'(dtsq_s2_reg) * TC_W'(T2_COLD_MUL);

        out_next.d1    = d1_s2_reg;
        out_next.temp1 = $signed({q[Q_W-1], q}) + BASE_T;
        out_next.a     = q;
        out_next.b     = $signed({q[Q_W-1], q}) + VCOLD_B;
        out_next.cold  = q[Q_W-1];
        out_next.vcold = (q < VCOLD_Q);
        out_next.off1  = OFF1_W'(off_sh)
                       + $signed({{(OFF1_W-COEF_W-OFF_SCALE){1'b0}},
                                  cfg.offset_coef, {OFF_SCALE{1'b0}}});
        out_next.sens1 = SENS1_W'(sens_sh)
                       + $signed({{(SENS1_W-COEF_W-SENS_SCALE){1'b0}},
                                  cfg.sens_coef, {SENS_SCALE{1'b0}}});
        if (q[Q_W-1])
        begin
            out_next.t2 = T2_W'(tc[TC_W-1:T2_COLD_SH]);
        end
        else
        begin
            out_next.t2 = T2_W'(tw[TW_W-1:T2_WARM_SH]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d1_s1_reg <= raw_pressure;
            dt_s1_reg <= dt_next;
        end
        if (en[1])
        begin
            d1_s2_reg    <= d1_s1_reg;
            ptemp_s2_reg <= ptemp_next;
            poff_s2_reg  <= poff_next;
            psens_s2_reg <= psens_next;
            dtsq_s2_reg  <= dtsq_full[DTSQ_W-1:0];
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

[sv/bsc_corr.sv]
`timescale 1ns / 1ps

module bsc_corr (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bsc_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bsc_pkg::corr_t   out_data
);
    import bsc_pkg::*;

    localparam int OA_W = SQ_W + 6;
    localparam int SA_W = SQ_W + 5;
    localparam logic signed [TEMP2_W-1:0] T_LOW  = TEMP2_W'(TEMP_LOW);
    localparam logic signed [TEMP2_W-1:0] T_HIGH = TEMP2_W'(TEMP_HIGH);

    logic [2:0] valid_reg;
    logic [2:0] en;

    front_t                  f_s4_reg;
    logic [SQ_W-1:0]         asq_s4_reg;
    logic [SQ_W-1:0]         bsq_s4_reg;
    logic signed [2*Q_W-1:0] asq_full;
    logic signed [2*B_W-1:0] bsq_full;

    logic        [RAW_W-1:0]      d1_s5_reg;
    logic signed [OFF1_W-1:0]     off1_s5_reg;
    logic signed [SENS1_W-1:0]    sens1_s5_reg;
    logic        [OFF2_W-1:0]     off2_s5_reg;
    logic        [SENS2_W-1:0]    sens2_s5_reg;
    logic signed [TEMP_OUT_W-1:0] temp_c_s5_reg;
    logic                         clip_t_s5_reg;
    logic        [OFF2_W-1:0]     off2_next;
    logic        [SENS2_W-1:0]    sens2_next;
    logic signed [TEMP_OUT_W-1:0] temp_c_next;
    logic                         clip_t_next;
    logic        [OA_W-1:0]       off2a;
    logic        [OFF2_W-1:0]     off2b;
    logic        [SA_W-1:0]       sens2a;
    logic        [SENS2_W-1:0]    sens2b;
    logic signed [TEMP2_W-1:0]    temp2;

    corr_t out_reg;
    corr_t out_next;

    always_comb
    begin
        en[2] = !valid_reg[2] || out_ready;
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_comb
    begin
        asq_full = in_data.a * in_data.a;
        bsq_full = in_data.b * in_data.b;
    end

    // second-order terms, corrected temperature
    always_comb
    begin
        off2a  = OA_W'(asq_s4_reg) * OA_W'(OFF2_COLD);
        off2b  = OFF2_W'(bsq_s4_reg) * OFF2_W'(OFF2_VCOLD);
        sens2a = SA_W'(asq_s4_reg) * SA_W'(SENS2_COLD);
        sens2b = SENS2_W'(bsq_s4_reg) * SENS2_W'(SENS2_VCOLD);

        off2_next  = '0;
        sens2_next = '0;
        if (f_s4_reg.cold)
        begin
            off2_next  = OFF2_W'(off2a[OA_W-1:SQ_SHIFT]);
            sens2_next = SENS2_W'(sens2a[SA_W-1:SQ_SHIFT]);
            if (f_s4_reg.vcold)
            begin
                off2_next  = off2_next + off2b;
                sens2_next = sens2_next + sens2b;
            end
        end

        temp2 = $signed({f_s4_reg.temp1[TEMP1_W-1], f_s4_reg.temp1})
              - $signed({{(TEMP2_W-T2_W){1'b0}}, f_s4_reg.t2});
        priority if (temp2 < T_LOW)
        begin
            temp_c_next = TEMP_OUT_W'(T_LOW);
            clip_t_next = 1'b1;
        end
        else if (temp2 > T_HIGH)
        begin
            temp_c_next = TEMP_OUT_W'(T_HIGH);
            clip_t_next = 1'b1;
        end
        else
        begin
            temp_c_next = TEMP_OUT_W'(temp2);
            clip_t_next = 1'b0;
        end
    end

    // corrected offset and sensitivity
    always_comb
    begin
        out_next.d1     = d1_s5_reg;
        out_next.temp_c = temp_c_s5_reg;
        out_next.clip_t = clip_t_s5_reg;
        out_next.off_f  = $signed({{(OFFF_W-OFF1_W){off1_s5_reg[OFF1_W-1]}}, off1_s5_reg})
                        - $signed({{(OFFF_W-OFF2_W){1'b0}}, off2_s5_reg});
        out_next.sens_f = $signed({{(SENSF_W-SENS1_W){sens1_s5_reg[SENS1_W-1]}},
                                   sens1_s5_reg})
                        - $signed({{(SENSF_W-SENS2_W){1'b0}}, sens2_s5_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f_s4_reg   <= in_data;
            asq_s4_reg <= asq_full[SQ_W-1:0];
            bsq_s4_reg <= bsq_full[SQ_W-1:0];
        end
        if (en[1])
        begin
            d1_s5_reg     <= f_s4_reg.d1;
            off1_s5_reg   <= f_s4_reg.off1;
            sens1_s5_reg  <= f_s4_reg.sens1;
            off2_s5_reg   <= off2_next;
            sens2_s5_reg  <= sens2_next;
            temp_c_s5_reg <= temp_c_next;
            clip_t_s5_reg <= clip_t_next;
        end
        if (en[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

[sv/bsc_press.sv]
`timescale 1ns / 1ps

module bsc_press (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  bsc_pkg::corr_t                        in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bsc_pkg::TEMP_OUT_W-1:0] temp_centi,
    output logic        [bsc_pkg::PRESS_OUT_W-1:0] press_centi_mbar,
    output logic                                  clipped
);
    import bsc_pkg::*;

    localparam int X_W = PROD_W - P1_SHIFT;
    localparam int Y_W = X_W + 1;
    localparam logic signed [PRESS_W-1:0] P_HIGH = PRESS_W'(PRESS_HIGH);

    logic [3:0] valid_reg;
    logic [3:0] en;

    logic        [PPLO_W-1:0]     pplo_s7_reg;
    logic signed [PPHI_W-1:0]     pphi_s7_reg;
    logic signed [OFFF_W-1:0]     off_s7_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s7_reg;
    logic                         clip_s7_reg;
    logic        [PPLO_W-1:0]     pplo_next;
    logic signed [PPHI_W-1:0]     pphi_next;

    logic signed [PROD_W-1:0]     prod_s8_reg;
    logic signed [OFFF_W-1:0]     off_s8_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s8_reg;
    logic                         clip_s8_reg;
    logic signed [PROD_W-1:0]     prod_next;

    logic signed [PRESS_W-1:0]    press_s9_reg;
    logic signed [TEMP_OUT_W-1:0] temp_s9_reg;
    logic                         clip_s9_reg;
    logic signed [X_W-1:0]        x;
    logic signed [Y_W-1:0]        y;

    logic signed [TEMP_OUT_W-1:0]  temp_out_reg;
    logic        [PRESS_OUT_W-1:0] press_out_reg;
    logic                          clip_out_reg;
    logic        [PRESS_OUT_W-1:0] press_out_next;
    logic                          clip_p_next;

    always_comb
    begin
        en[3] = !valid_reg[3] || out_ready;
        en[2] = !valid_reg[2] || en[3];
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
    end

    assign in_ready         = en[0];
    assign out_valid        = valid_reg[3];
    assign temp_centi       = temp_out_reg;
    assign press_centi_mbar = press_out_reg;
    assign clipped          = clip_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
            if (en[3])
            begin
                valid_reg[3] <= valid_reg[2];
            end
        end
    end

    // D1 * SENS as two partial products
    always_comb
    begin
        pplo_next = PPLO_W'(in_data.d1) * PPLO_W'(in_data.sens_f[LO_W-1:0]);
        pphi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens_f[SENSF_W-1:LO_W]);
    end

    always_comb
    begin
        prod_next = $signed({pphi_s7_reg, {LO_W{1'b0}}})
                  + $signed({{(PROD_W-PPLO_W){1'b0}}, pplo_s7_reg});
    end

    always_comb
    begin
        x = $signed(prod_s8_reg[PROD_W-1:P1_SHIFT]);
        y = $signed({x[X_W-1], x})
          - $signed({{(Y_W-OFFF_W){off_s8_reg[OFFF_W-1]}}, off_s8_reg});
    end

    always_comb
    begin
        priority if (press_s9_reg < 0)
        begin
            press_out_next = '0;
            clip_p_next    = 1'b1;
        end
        else if (press_s9_reg > P_HIGH)
        begin
            press_out_next = PRESS_OUT_W'(P_HIGH);
            clip_p_next    = 1'b1;
        end
        else
        begin
            press_out_next = PRESS_OUT_W'(press_s9_reg);
            clip_p_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pplo_s7_reg <= pplo_next;
            pphi_s7_reg <= pphi_next;
            off_s7_reg  <= in_data.off_f;
            temp_s7_reg <= in_data.temp_c;
            clip_s7_reg <= in_data.clip_t;
        end
        if (en[1])
        begin
            prod_s8_reg <= prod_next;
            off_s8_reg  <= off_s7_reg;
            temp_s8_reg <= temp_s7_reg;
            clip_s8_reg <= clip_s7_reg;
        end
        if (en[2])
        begin
            press_s9_reg <= $signed(y[Y_W-1:P2_SHIFT]);
            temp_s9_reg  <= temp_s8_reg;
            clip_s9_reg  <= clip_s8_reg;
        end
        if (en[3])
        begin
            temp_out_reg  <= temp_s9_reg;
            press_out_reg <= press_out_next;
            clip_out_reg  <= clip_s9_reg | clip_p_next;
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import bsc_pkg::*;

    localparam int     PHASES         = 8;
    localparam int     PHASE_SAMPLES  = 225;
    localparam int     QUIET_LIMIT    = 5000;
    localparam int     LONG_HOLD      = 400;
    localparam int     SETTLE_CYCLES  = 30;
    localparam longint RAW_MAX        = 16777215;
    localparam logic [RAW_W-1:0] TYP_PRESS = 24'd6465444;
    localparam logic [RAW_W-1:0] TYP_TEMP  = 24'd8077636;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd6;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temp;
        logic        [PRESS_OUT_W-1:0] press;
        logic                          clip;
    } reading_t;

    class reading_scoreboard;
        logic [COEF_W-1:0] coef [6];
        reading_t          expected_readings [$];
        int                errors;

        function new();
            foreach (coef[i])
                coef[i] = '0;
            errors = 0;
        endfunction

        function void set_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
            if (idx <= REG_TEMP_SLOPE_COEF)
                coef[idx] = val;
        endfunction

        function reading_t compensate(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
            longint   d1, dt, tc, off, sens, t2, off2, sens2, pr, a, b;
            bit       clip;
            reading_t r;
            d1   = longint'(p);
            dt   = longint'(t) - longint'(coef[REG_REF_TEMP_COEF]) * 256;
            tc   = 2000 + ((dt * longint'(coef[REG_TEMP_SLOPE_COEF])) >>> 23);
            off  = longint'(coef[REG_OFFSET_COEF]) * 131072
                   + ((longint'(coef[REG_OFFSET_TEMPCO]) * dt) >>> 6);
            sens = longint'(coef[REG_SENS_COEF]) * 65536
                   + ((longint'(coef[REG_SENS_TEMPCO]) * dt) >>> 7);
            if (tc >= 2000)
            begin
                t2    = (5 * dt * dt) >>> 38;
                off2  = 0;
                sens2 = 0;
            end
            else
            begin
                a     = tc - 2000;
                t2    = (3 * dt * dt) >>> 33;
                off2  = (61 * a * a) >>> 4;
                sens2 = (29 * a * a) >>> 4;
                if (tc < -1500)
                begin
                    b     = tc + 1500;
                    off2  = off2 + 17 * b * b;
                    sens2 = sens2 + 9 * b * b;
                end
            end
            tc   = tc - t2;
            off  = off - off2;
            sens = sens - sens2;
            pr   = (((d1 * sens) >>> 21) - off) >>> 15;
            clip = 1'b0;
            if (tc < -4000)
            begin
                tc   = -4000;
                clip = 1'b1;
            end
            if (tc > 8500)
            begin
                tc   = 8500;
                clip = 1'b1;
            end
            if (pr < 0)
            begin
                pr   = 0;
                clip = 1'b1;
            end
            if (pr > 200000)
            begin
                pr   = 200000;
                clip = 1'b1;
            end
            r.temp  = tc[TEMP_OUT_W-1:0];
            r.press = pr[PRESS_OUT_W-1:0];
            r.clip  = clip;
            return r;
        endfunction

        function void note_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
            expected_readings.push_back(compensate(p, t));
        endfunction

        function void check_result(input logic signed [TEMP_OUT_W-1:0] temp,
                                   input logic [PRESS_OUT_W-1:0] press,
                                   input logic clip);
            reading_t e;
            if (expected_readings.size() == 0)
            begin
                errors++;
                $error("unexpected result transaction: temp_centi %0d press_centi_mbar %0d",
                       temp, press);
                return;
            end
            e = expected_readings.pop_front();
            if (temp !== e.temp)
            begin
                errors++;
                $error("temp_centi: expected %0d, actual %0d", e.temp, temp);
            end
            if (press !== e.press)
            begin
                errors++;
                $error("press_centi_mbar: expected %0d, actual %0d", e.press, press);
            end
            if (clip !== e.clip)
            begin
                errors++;
                $error("clipped: expected %0d, actual %0d", e.clip, clip);
            end
        endfunction

        function int outstanding();
            return expected_readings.size();
        endfunction
    endclass

    logic                          clk             = 1'b0;
    logic                          rst_n           = 1'b0;
    logic                          cfg_valid       = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index       = '0;
    logic [COEF_W-1:0]             cfg_data        = '0;
    logic                          in_valid        = 1'b0;
    logic                          in_ready;
    logic [RAW_W-1:0]              raw_pressure    = '0;
    logic [RAW_W-1:0]              raw_temperature = '0;
    logic                          out_valid;
    logic                          out_ready       = 1'b0;
    logic signed [TEMP_OUT_W-1:0]  temp_centi;
    logic        [PRESS_OUT_W-1:0] press_centi_mbar;
    logic                          clipped;

    reading_scoreboard sb;
    logic [COEF_W-1:0] coef_set [6];
    int                send_idle_pct = 0;
    int                stall_pct     = 0;
    int                hold_cycles   = 0;
    int                quiet_cycles  = 0;

    baro_sensor_compensation uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .raw_pressure     (raw_pressure),
        .raw_temperature  (raw_temperature),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .temp_centi       (temp_centi),
        .press_centi_mbar (press_centi_mbar),
        .clipped          (clipped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_sample(raw_pressure, raw_temperature);
            if (out_valid && out_ready)
                sb.check_result(temp_centi, press_centi_mbar, clipped);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : receiver
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 69; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 69; end
            IDLE_BOTH:     begin send_idle_pct = 23; stall_pct = 23; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_coef(idx, val);
        @(negedge clk);
    endtask

    // spare index is written too; the block must ignore it
    task automatic write_coefs();
        for (int i = 0; i < 6; i++)
            write_reg(CFG_IDX_W'(i), coef_set[i]);
        write_reg(CFG_SPARE_FIRST + CFG_IDX_W'($urandom_range(1)), COEF_W'($urandom()));
        cfg_valid = 1'b0;
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        raw_pressure    = p;
        raw_temperature = t;
        in_valid        = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_sample();
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;
        longint           v;
        int               kind;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            // around the reference point: warm, cold and very cold ranges
            v = longint'(sb.coef[REG_REF_TEMP_COEF]) * 256
                + longint'($urandom_range(5000000)) - 2500000;
            if (v < 0)
                v = 0;
            else if (v > RAW_MAX)
                v = RAW_MAX;
            t = v[RAW_W-1:0];
            p = RAW_W'($urandom_range(10000000, 2000000));
        end
        else if (kind < 80)
        begin
            t = $urandom_range(1) ? '1 : '0;
            p = $urandom_range(1) ? '1 : RAW_W'($urandom());
        end
        else
        begin
            t = RAW_W'($urandom());
            p = RAW_W'($urandom());
        end
        send_sample(p, t);
    endtask

    // raw temperature whose first-order result is 2000 + k, for k <= 0
    function automatic logic [RAW_W-1:0] temp_code(input int k);
        longint v;
        v = longint'(sb.coef[REG_REF_TEMP_COEF]) * 256
            + (longint'(k) * 8388608) / longint'(sb.coef[REG_TEMP_SLOPE_COEF]);
        return v[RAW_W-1:0];
    endfunction

    task automatic drain();
        in_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_idling(IDLE_NONE);

        coef_set = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
        write_coefs();
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample('0, '1);
        send_sample('1, '0);
        send_sample(TYP_PRESS, TYP_TEMP);
        send_sample(TYP_PRESS, temp_code(0));
        send_sample(TYP_PRESS, temp_code(0) - 1'b1);
        send_sample(TYP_PRESS, temp_code(-3500));
        send_sample(TYP_PRESS, temp_code(-3500) - 1'b1);
        send_sample(TYP_PRESS, temp_code(-6500));
        send_sample('0, TYP_TEMP);
        send_sample('1, TYP_TEMP);
        send_sample(TYP_PRESS, temp_code(0) + 24'd2500000);
        drain();

        coef_set = '{default: 16'hFFFF};
        write_coefs();
        send_sample('1, '1);
        send_sample('1, '0);
        send_sample('0, '0);
        send_sample(24'h800000, 24'h800000);
        drain();

        coef_set = '{default: 16'h0000};
        write_coefs();
        send_sample('1, '1);
        send_sample(24'h123456, 24'h654321);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                coef_set = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
            else if (ph == 1)
                coef_set = '{default: 16'hFFFF};
            else
            begin
                foreach (coef_set[i])
                begin
                    case ($urandom_range(9))
                        0:       coef_set[i] = '0;
                        1:       coef_set[i] = '1;
                        default: coef_set[i] = COEF_W'($urandom());
                    endcase
                end
            end
            write_coefs();
            set_idling(idle_mode_t'(ph % 4));
            if (ph == 4)
                hold_cycles = LONG_HOLD;
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if ((ph % 4 == 2) && (n == PHASE_SAMPLES / 2))
                    drain();
                send_random_sample();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/bsc_pkg.sv
sv/bsc_front.sv
sv/bsc_corr.sv
sv/bsc_press.sv
sv/baro_sensor_compensation.sv
test/tb_top.sv
